// ===== hdl/epsgd_pkg.sv =====
// package for the embedding pair sgd update unit
// holds item types, command codes, control and status structs and widths
// no dependencies
package epsgd_pkg;

  localparam int unsigned NODES_DEF = 4096;
  localparam int unsigned DIM_DEF   = 10;

  localparam logic [31:0] LR_RESET   = 32'd28147498;
  localparam logic [47:0] BIAS_RESET = 48'd0;

  // configuration address decode
  localparam int unsigned PADDR_W      = 4;
  localparam int unsigned REG_SEL_BIT  = 3;
  localparam logic        REG_IDX_LR   = 1'b0;
  localparam logic        REG_IDX_BIAS = 1'b1;

  // shared serial multiplier
  localparam int unsigned MA_W = 128;
  localparam int unsigned MB_W = 64;
  localparam int unsigned MP_W = MA_W + MB_W;
  localparam int unsigned MN_W = 7;

  // arithmetic widths
  localparam int unsigned S_W    = 56;
  localparam int unsigned LNS_W  = 58;
  localparam int unsigned DIFF_W = 59;
  localparam int unsigned MAG_W  = 58;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TRAIN = 2'd2,
    CMD_LOSS  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [11:0]        node_a;
    logic [11:0]        node_b;
    logic [5:0]         elem_index;
    logic signed [31:0] load_value;
    logic [31:0]        weight;
    logic signed [31:0] log_weight;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [63:0]        loss_term;
    logic signed [63:0] c_num_term;
    logic [31:0]        c_den_term;
  } out_item_t;

  typedef enum logic [2:0] {
    MOP_SQ_SUM  = 3'd0,
    MOP_SQ_DIFF = 3'd1,
    MOP_LOSS_W  = 3'd2,
    MOP_LNS_W   = 3'd3,
    MOP_LR_W    = 3'd4,
    MOP_GWD     = 3'd5,
    MOP_INC     = 3'd6
  } mop_e;

  typedef enum logic [1:0] {
    ASEL_ELEM = 2'd0,
    ASEL_A_J  = 2'd1,
    ASEL_B_J  = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_LOAD  = 2'd0,
    WSEL_NEW_A = 2'd1,
    WSEL_NEW_B = 2'd2
  } wd_sel_e;

  typedef struct packed {
    logic      cap_item;
    logic      ram_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      cap_a;
    logic      cap_b;
    logic      j_clr;
    logic      j_inc;
    logic      s_clr;
    logic      mul_start;
    mop_e      mop;
    logic      calc_diff;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic ok;
    logic j_last;
    logic mul_done;
  } dp_sts_t;

endpackage

// ===== hdl/embedding_pair_sgd_update_unit.sv =====
// Embedding pair SGD update unit. Holds NODES rows of DIM signed Q8.24 elements
// in a single-port table and handles one transaction at a time. How long a
// transaction takes is set by the shared multiplier, which retires one operand bit
// per cycle (33 bits per element square or increment, 32 or 58 for the scalar
// products), and by the single table port, which reads and writes one element per
// cycle. A finished result waits in an output register while the next item is taken.
// Configuration writes (learning rate at 0x0, bias C at 0x8) belong in idle time.
// depends on epsgd_pkg, epsgd_ctrl, epsgd_dp
module embedding_pair_sgd_update_unit #(
  parameter int unsigned NODES = epsgd_pkg::NODES_DEF,
  parameter int unsigned DIM   = epsgd_pkg::DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  epsgd_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output epsgd_pkg::out_item_t          out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epsgd_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import epsgd_pkg::*;

  logic [31:0] lr_q;
  logic [47:0] bias_q;
  logic        cfg_wr;
  ctrl_cmd_t   cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LR_RESET;
      bias_q <= BIAS_RESET;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_IDX_LR) begin
        lr_q <= pwdata[31:0];
      end else begin
        bias_q <= pwdata[47:0];
      end
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_IDX_BIAS) ? {16'd0, bias_q} : {32'd0, lr_q};

  epsgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  epsgd_dp #(
    .NODES (NODES),
    .DIM   (DIM)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .lr_i       (lr_q),
    .bias_i     ($signed(bias_q)),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/epsgd_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module epsgd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/epsgd_mul.sv =====
// shift-add multiplier, one bit of the b operand per cycle
// depends on epsgd_pkg
module epsgd_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [epsgd_pkg::MA_W-1:0]  a_i,
  input  logic [epsgd_pkg::MB_W-1:0]  b_i,
  input  logic [epsgd_pkg::MN_W-1:0]  nbits_i,
  output logic                        done_o,
  output logic [epsgd_pkg::MP_W-1:0]  product_o
);
  import epsgd_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [MN_W-1:0] cnt_q;
  logic [MP_W-1:0] acc_q;
  logic [MP_W-1:0] a_sh_q;
  logic [MB_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - MN_W'(1);
      done_q <= (cnt_q == MN_W'(1));
      busy_q <= (cnt_q != MN_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      a_sh_q <= MP_W'(a_i);
      b_q    <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_sh_q;
      end
      a_sh_q <= a_sh_q << 1;
      b_q    <= b_q >> 1;
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== hdl/epsgd_dp.sv =====
// datapath: item registers, embedding table, multiplier operand and result logic
// depends on epsgd_pkg, epsgd_ram, epsgd_mul
module epsgd_dp #(
  parameter int unsigned NODES = epsgd_pkg::NODES_DEF,
  parameter int unsigned DIM   = epsgd_pkg::DIM_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  epsgd_pkg::in_item_t     in_data_i,
  input  logic [31:0]             lr_i,
  input  logic signed [47:0]      bias_i,
  input  epsgd_pkg::ctrl_cmd_t    cmd_i,
  output epsgd_pkg::dp_sts_t      sts_o,
  output epsgd_pkg::out_item_t    out_data_o
);
  import epsgd_pkg::*;

  localparam int unsigned DEPTH = NODES * DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned JW    = (DIM > 1) ? $clog2(DIM) : 1;

  localparam logic [MN_W-1:0] N_SUM  = MN_W'(33);
  localparam logic [MN_W-1:0] N_MAG  = MN_W'(MAG_W);
  localparam logic [MN_W-1:0] N_WORD = MN_W'(32);

  localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [36:0] SAT_LO = -37'sd2147483648;
  localparam logic [60:0]        IM_MAX = 61'd1 << 33;
  localparam logic [73:0]        CN_POS = (74'd1 << 63) - 74'd1;
  localparam logic [73:0]        CN_NEG = 74'd1 << 63;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  in_item_t                  item_q;
  logic                      ok_q;
  logic                      ok_c;
  logic signed [31:0]        a_q, b_q;
  logic [JW-1:0]             j_q;
  logic [S_W-1:0]            s_q;
  logic signed [LNS_W-1:0]   lns_q, lns_c;
  logic signed [DIFF_W-1:0]  diff_q, diff_c;
  logic [115:0]              d2_q;
  logic [63:0]               loss_q, loss_c;
  logic [63:0]               cnum_q, cnum_c;
  logic [63:0]               gw_q;
  logic [121:0]              gwd_q;
  logic signed [31:0]        new_a_q, new_b_q, new_a_c, new_b_c, base_b;
  out_item_t                 out_q, res_c;

  logic signed [32:0]        sum;
  logic                      sum_neg;
  logic [32:0]               sum_mag;
  logic                      lns_neg, diff_neg;
  logic [MAG_W-1:0]          lns_mag, diff_mag;

  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [MN_W-1:0]           mul_n;
  logic                      mul_done;
  logic [MP_W-1:0]           prod;

  logic [60:0]               inc_r;
  logic [33:0]               im;
  logic [36:0]               inc_mag;
  logic signed [36:0]        inc;
  logic [73:0]               cn_v, cn_lim, cn_s;

  logic [11:0]               node_sel;
  logic [31:0]               idx_sel;
  logic [31:0]               addr_full;
  logic [31:0]               wdata;
  logic [31:0]               rdata;

  // item checks
  always_comb begin
    if (in_data_i.cmd == CMD_LOAD || in_data_i.cmd == CMD_READ) begin
      ok_c = (32'(in_data_i.node_a) < NODES) && (32'(in_data_i.elem_index) < DIM);
    end else begin
      ok_c = (32'(in_data_i.node_a) < NODES) && (32'(in_data_i.node_b) < NODES);
    end
  end

  assign sum      = 33'(a_q) + 33'(b_q);
  assign sum_neg  = sum[32];
  assign sum_mag  = sum_neg ? 33'(-sum) : 33'(sum);

  assign lns_c    = ((LNS_W'(item_q.log_weight)) <<< 8) - $signed({2'b00, s_q});
  assign diff_c   = DIFF_W'(lns_c) - DIFF_W'(bias_i);
  assign lns_neg  = lns_q[LNS_W-1];
  assign diff_neg = diff_q[DIFF_W-1];
  assign lns_mag  = lns_neg ? MAG_W'(-lns_q) : MAG_W'(lns_q);
  assign diff_mag = diff_neg ? MAG_W'(-diff_q) : MAG_W'(diff_q);

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_n = N_WORD;
    unique case (cmd_i.mop)
      MOP_SQ_SUM: begin
        mul_a = MA_W'(sum_mag);
        mul_b = MB_W'(sum_mag);
        mul_n = N_SUM;
      end
      MOP_SQ_DIFF: begin
        mul_a = MA_W'(diff_mag);
        mul_b = MB_W'(diff_mag);
        mul_n = N_MAG;
      end
      MOP_LOSS_W: begin
        mul_a = MA_W'(d2_q);
        mul_b = MB_W'(item_q.weight);
      end
      MOP_LNS_W: begin
        mul_a = MA_W'(lns_mag);
        mul_b = MB_W'(item_q.weight);
      end
      MOP_LR_W: begin
        mul_a = MA_W'(lr_i);
        mul_b = MB_W'(item_q.weight);
      end
      MOP_GWD: begin
        mul_a = MA_W'(gw_q);
        mul_b = MB_W'(diff_mag);
        mul_n = N_MAG;
      end
      MOP_INC: begin
        mul_a = MA_W'(gwd_q);
        mul_b = MB_W'(sum_mag);
        mul_n = N_SUM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_n = N_WORD;
      end
    endcase
  end

  epsgd_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .nbits_i   (mul_n),
    .done_o    (mul_done),
    .product_o (prod)
  );

  // loss term: drop 48 fraction bits, saturate to 64 bits
  assign loss_c = (|prod[147:112]) ? '1 : prod[111:48];

  // bias refit numerator, signed saturation of the magnitude
  assign cn_v   = prod[89:16];
  assign cn_lim = lns_neg ? CN_NEG : CN_POS;
  assign cn_s   = (cn_v > cn_lim) ? cn_lim : cn_v;
  assign cnum_c = lns_neg ? (64'd0 - cn_s[63:0]) : cn_s[63:0];

  // element increment and updated elements
  assign inc_r   = prod[154:94];
  assign im      = (inc_r > IM_MAX) ? 34'(IM_MAX) : inc_r[33:0];
  assign inc_mag = {3'b000, im};
  assign inc     = (diff_neg ^ sum_neg) ? -$signed(inc_mag) : $signed(inc_mag);
  assign new_a_c = sat32(37'(a_q) + inc);
  // same node twice: second update builds on the first
  assign base_b  = (item_q.node_a == item_q.node_b) ? new_a_c : b_q;
  assign new_b_c = sat32(37'(base_b) + inc);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q <= in_data_i;
      ok_q   <= ok_c;
    end
    if (cmd_i.cap_a) begin
      a_q <= $signed(rdata);
    end
    if (cmd_i.cap_b) begin
      b_q <= $signed(rdata);
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + JW'(1);
    end
    if (cmd_i.calc_diff) begin
      lns_q  <= lns_c;
      diff_q <= diff_c;
    end
    if (cmd_i.s_clr) begin
      s_q <= '0;
    end else if (mul_done && cmd_i.mop == MOP_SQ_SUM) begin
      s_q <= s_q + S_W'(prod[65:16]);
    end
    if (mul_done) begin
      unique case (cmd_i.mop)
        MOP_SQ_SUM:  ;
        MOP_SQ_DIFF: d2_q   <= prod[115:0];
        MOP_LOSS_W:  loss_q <= loss_c;
        MOP_LNS_W:   cnum_q <= cnum_c;
        MOP_LR_W:    gw_q   <= prod[63:0];
        MOP_GWD:     gwd_q  <= prod[121:0];
        MOP_INC: begin
          new_a_q <= new_a_c;
          new_b_q <= new_b_c;
        end
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= res_c;
    end
  end

  // table address and write data
  always_comb begin
    node_sel = item_q.node_a;
    idx_sel  = 32'(j_q);
    unique case (cmd_i.addr_sel)
      ASEL_ELEM: idx_sel = 32'(item_q.elem_index);
      ASEL_A_J:  node_sel = item_q.node_a;
      ASEL_B_J:  node_sel = item_q.node_b;
      default:   node_sel = item_q.node_a;
    endcase
  end

  assign addr_full = 32'(node_sel) * 32'(DIM) + idx_sel;

  always_comb begin
    unique case (cmd_i.wd_sel)
      WSEL_LOAD:  wdata = item_q.load_value;
      WSEL_NEW_A: wdata = new_a_q;
      WSEL_NEW_B: wdata = new_b_q;
      default:    wdata = item_q.load_value;
    endcase
  end

  epsgd_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .addr_i  (addr_full[AW-1:0]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // result item
  always_comb begin
    res_c = '0;
    unique case (item_q.cmd)
      CMD_LOAD: ;
      CMD_READ: begin
        if (ok_q) res_c.read_value = a_q;
      end
      CMD_TRAIN: begin
        if (ok_q) begin
          res_c.c_num_term = $signed(cnum_q);
          res_c.c_den_term = item_q.weight;
        end
      end
      CMD_LOSS: begin
        if (ok_q) res_c.loss_term = loss_q;
      end
      default: ;
    endcase
  end

  assign sts_o.cmd      = item_q.cmd;
  assign sts_o.ok       = ok_q;
  assign sts_o.j_last   = (32'(j_q) == DIM - 1);
  assign sts_o.mul_done = mul_done;
  assign out_data_o     = out_q;

endmodule

// ===== hdl/epsgd_ctrl.sv =====
// controller state machine: sequences table passes and multiplier operations
// depends on epsgd_pkg
module epsgd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  epsgd_pkg::dp_sts_t    sts_i,
  output epsgd_pkg::ctrl_cmd_t  cmd_o
);
  import epsgd_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_DISPATCH = 12'b000000000010,
    ST_RD_CAP   = 12'b000000000100,
    ST_SA       = 12'b000000001000,
    ST_SB       = 12'b000000010000,
    ST_SBC      = 12'b000000100000,
    ST_MOP      = 12'b000001000000,
    ST_MOPW     = 12'b000010000000,
    ST_DIFF     = 12'b000100000000,
    ST_WA       = 12'b001000000000,
    ST_WB       = 12'b010000000000,
    ST_RESULT   = 12'b100000000000
  } state_e;

  state_e    state_q, state_d;
  mop_e      op_q, op_d;
  logic      out_valid_q;
  ctrl_cmd_t c;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    c          = '0;
    c.mop      = op_q;
    c.addr_sel = ASEL_ELEM;
    c.wd_sel   = WSEL_LOAD;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c.cap_item = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_LOAD: begin
            c.ram_we = sts_i.ok;
            state_d  = ST_RESULT;
          end
          CMD_READ: state_d = ST_RD_CAP;
          CMD_TRAIN, CMD_LOSS: begin
            if (sts_i.ok) begin
              c.j_clr = 1'b1;
              c.s_clr = 1'b1;
              op_d    = MOP_SQ_SUM;
              state_d = ST_SA;
            end else begin
              state_d = ST_RESULT;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_RD_CAP: begin
        c.cap_a = 1'b1;
        state_d = ST_RESULT;
      end
      ST_SA: begin
        c.addr_sel = ASEL_A_J;
        state_d    = ST_SB;
      end
      ST_SB: begin
        c.addr_sel = ASEL_B_J;
        c.cap_a    = 1'b1;
        state_d    = ST_SBC;
      end
      ST_SBC: begin
        c.cap_b = 1'b1;
        state_d = ST_MOP;
      end
      ST_MOP: begin
        c.mul_start = 1'b1;
        state_d     = ST_MOPW;
      end
      ST_MOPW: begin
        if (sts_i.mul_done) begin
          unique case (op_q)
            MOP_SQ_SUM: begin
              if (sts_i.j_last) begin
                state_d = ST_DIFF;
              end else begin
                c.j_inc = 1'b1;
                state_d = ST_SA;
              end
            end
            MOP_SQ_DIFF: begin
              op_d    = MOP_LOSS_W;
              state_d = ST_MOP;
            end
            MOP_LOSS_W: state_d = ST_RESULT;
            MOP_LNS_W: begin
              op_d    = MOP_LR_W;
              state_d = ST_MOP;
            end
            MOP_LR_W: begin
              op_d    = MOP_GWD;
              state_d = ST_MOP;
            end
            MOP_GWD: begin
              // second pass over both rows
              op_d    = MOP_INC;
              c.j_clr = 1'b1;
              state_d = ST_SA;
            end
            MOP_INC: state_d = ST_WA;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIFF: begin
        c.calc_diff = 1'b1;
        op_d        = (sts_i.cmd == CMD_LOSS) ? MOP_SQ_DIFF : MOP_LNS_W;
        state_d     = ST_MOP;
      end
      ST_WA: begin
        c.ram_we   = 1'b1;
        c.addr_sel = ASEL_A_J;
        c.wd_sel   = WSEL_NEW_A;
        state_d    = ST_WB;
      end
      ST_WB: begin
        c.ram_we   = 1'b1;
        c.addr_sel = ASEL_B_J;
        c.wd_sel   = WSEL_NEW_B;
        if (sts_i.j_last) begin
          state_d = ST_RESULT;
        end else begin
          c.j_inc = 1'b1;
          state_d = ST_SA;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          c.out_load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= MOP_SQ_SUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (c.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o       = c;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> state_q == ST_MOPW)
    else $error("multiplier finished outside its wait state");

  a_write_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c.ram_we |-> sts_i.ok)
    else $error("table write for a rejected item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DISPATCH && out_valid_q == $past(out_valid_q)
      || state_q == ST_DISPATCH && !$past(out_valid_q && out_stall_i)))
    else $error("accepted transaction not dispatched");

endmodule

// ===== test/embedding_pair_sgd_update_unit_chk.sv =====
// checker for the embedding pair sgd update unit: watches both channels and the
// register port, predicts every result from its own table copy and compares
// depends on epsgd_pkg
module embedding_pair_sgd_update_unit_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  epsgd_pkg::in_item_t           in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  epsgd_pkg::out_item_t          out_data_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epsgd_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o
);
  import epsgd_pkg::*;

  localparam int unsigned NODES = NODES_DEF;
  localparam int unsigned DIM   = DIM_DEF;

  logic signed [31:0] emb_rows [NODES*DIM];
  logic [31:0]        gamma_q;
  logic signed [47:0] bias_q;
  out_item_t          expected_results [$];
  int                 mismatches;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // one sgd step or loss evaluation on the local table copy
  function automatic out_item_t sgd_step(in_item_t it);
    out_item_t          r;
    logic signed [33:0] sums [DIM];
    logic [191:0]       mg [DIM];
    logic signed [33:0] ea, eb;
    logic [191:0]       p, dm, lm, w, g, lim;
    longint             s, lns, diff, inc;
    int unsigned        a, b;
    logic               neg;
    r = '0;
    a = 32'(it.node_a);
    b = 32'(it.node_b);
    w = 192'(it.weight);
    case (it.cmd)
      CMD_LOAD: begin
        if (it.elem_index < DIM) emb_rows[a*DIM + it.elem_index] = it.load_value;
        return r;
      end
      CMD_READ: begin
        if (it.elem_index < DIM) r.read_value = emb_rows[a*DIM + it.elem_index];
        return r;
      end
      default: ;
    endcase
    s = 0;
    for (int j = 0; j < DIM; j++) begin
      ea = 34'(emb_rows[a*DIM + j]);
      eb = 34'(emb_rows[b*DIM + j]);
      sums[j] = ea + eb;
      mg[j] = sums[j][33] ? 192'(-sums[j]) : 192'(sums[j]);
      p = mg[j] * mg[j];
      s += longint'(p >> 16);
    end
    lns = longint'(it.log_weight) * 256 - s;
    diff = lns - longint'(bias_q);
    dm = diff < 0 ? 192'(-diff) : 192'(diff);
    if (it.cmd == CMD_LOSS) begin
      p = (dm * dm * w) >> 48;
      r.loss_term = |p[191:64] ? '1 : p[63:0];
      return r;
    end
    neg = lns < 0;
    lm = neg ? 192'(-lns) : 192'(lns);
    p = (lm * w) >> 16;
    lim = neg ? (192'(1) << 63) : (192'(1) << 63) - 1;
    if (p > lim) p = lim;
    r.c_num_term = neg ? -p[63:0] : p[63:0];
    r.c_den_term = it.weight;
    g = 192'(gamma_q);
    for (int j = 0; j < DIM; j++) begin
      p = (g * w * dm * mg[j]) >> 94;
      if (p > (192'(1) << 33)) p = 192'(1) << 33;
      inc = ((diff < 0) != sums[j][33]) ? -longint'(p[63:0]) : longint'(p[63:0]);
      // with a equal to b the second add sees the first one
      emb_rows[a*DIM + j] = clip32(longint'(emb_rows[a*DIM + j]) + inc);
      emb_rows[b*DIM + j] = clip32(longint'(emb_rows[b*DIM + j]) + inc);
    end
    return r;
  endfunction

  function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", name, exp_v, got_v);
  endfunction

  initial begin
    foreach (emb_rows[i]) emb_rows[i] = '0;
    mismatches = 0;
  end

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t ex;
    if (!rst_ni) begin
      gamma_q <= LR_RESET;
      bias_q  <= BIAS_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[REG_SEL_BIT] == REG_IDX_BIAS) bias_q <= pwdata[47:0];
        else gamma_q <= pwdata[31:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", out_data_i);
        end else begin
          ex = expected_results.pop_front();
          if (out_data_i.read_value !== ex.read_value)
            report_field("read_value", 64'(ex.read_value), 64'(out_data_i.read_value));
          if (out_data_i.loss_term !== ex.loss_term)
            report_field("loss_term", ex.loss_term, out_data_i.loss_term);
          if (out_data_i.c_num_term !== ex.c_num_term)
            report_field("c_num_term", ex.c_num_term, out_data_i.c_num_term);
          if (out_data_i.c_den_term !== ex.c_den_term)
            report_field("c_den_term", 64'(ex.c_den_term), 64'(out_data_i.c_den_term));
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(sgd_step(in_data_i));
    end
  end

endmodule

// ===== test/embedding_pair_sgd_update_unit_tb.sv =====
// testbench top for the embedding pair sgd update unit: makes stimulus and
// register writes, idles both channels and gives the verdict
// depends on epsgd_pkg, embedding_pair_sgd_update_unit, embedding_pair_sgd_update_unit_chk
module embedding_pair_sgd_update_unit_tb;
  import epsgd_pkg::*;

  localparam int unsigned DIM   = DIM_DEF;
  localparam int unsigned NPOOL = 6;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [63:0]          pwdata = '0, prdata;
  logic                 pready;
  int                   fail_count, pending;
  logic                 idle_on = 1'b1;
  logic                 hold_rx = 1'b0;
  logic [11:0]          rows [NPOOL];

  always #6 clk_i = ~clk_i;

  embedding_pair_sgd_update_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  embedding_pair_sgd_update_unit_chk chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_stall <= hold_rx || (idle_on && $urandom_range(99) < 12);

  initial begin
    #(12 * 4000000);
    $display("tb: failure");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(in_item_t it);
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic reg_idx, logic [63:0] value);
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(reg_idx) << REG_SEL_BIT;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(cmd_e cmd, logic [11:0] a, logic [11:0] b,
                                         logic [5:0] ei, logic [31:0] ld,
                                         logic [31:0] w, logic [31:0] lnw);
    in_item_t it;
    it.cmd = cmd; it.node_a = a; it.node_b = b; it.elem_index = ei;
    it.load_value = ld; it.weight = w; it.log_weight = lnw;
    return it;
  endfunction

  function automatic logic [31:0] small_signed(int unsigned span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it = make_item(cmd_e'($urandom_range(3)), 12'($urandom), 12'($urandom),
                   6'($urandom), $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.cmd = CMD_LOAD;
      if ($urandom_range(9) != 0) begin
        it.node_a = rows[$urandom_range(NPOOL-1)];
        it.elem_index = 6'($urandom_range(DIM-1));
        if ($urandom_range(4) != 0) it.load_value = small_signed(1 << 25);
      end else it.elem_index = 6'($urandom_range(63, DIM));
    end else if (pick < 50) begin
      it.cmd = CMD_READ;
      if ($urandom_range(6) != 0) begin
        it.node_a = rows[$urandom_range(NPOOL-1)];
        it.elem_index = 6'($urandom_range(DIM-1));
      end else it.elem_index = 6'($urandom_range(63, DIM));
    end else begin
      it.cmd = pick < 80 ? CMD_TRAIN : CMD_LOSS;
      it.node_a = rows[$urandom_range(NPOOL-1)];
      it.node_b = $urandom_range(4) == 0 ? it.node_a : rows[$urandom_range(NPOOL-1)];
      if ($urandom_range(2) != 0) it.weight = $urandom_range(1 << 22);
      if ($urandom_range(2) != 0) it.log_weight = small_signed(1 << 27);
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_item(random_item());
  endtask

  initial begin
    rows[0] = 12'd0;
    rows[1] = 12'hfff;
    for (int i = 2; i < NPOOL; i++) rows[i] = 12'($urandom);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // every pool row is loaded before anything reads it
    for (int r = 0; r < NPOOL; r++)
      for (int j = 0; j < DIM; j++)
        send_item(make_item(CMD_LOAD, rows[r], 12'($urandom), 6'(j), small_signed(1 << 24),
                            $urandom, $urandom));
    // field extremes and corner cases
    send_item(make_item(CMD_READ, rows[1], 12'h000, 6'(DIM-1), '0, '0, '0));
    send_item(make_item(CMD_TRAIN, rows[2], rows[3], '0, '0, 32'h0001_0000, 32'h0100_0000));
    send_item(make_item(CMD_TRAIN, rows[4], rows[4], '0, '0, 32'h0004_0000, 32'h0200_0000));
    send_item(make_item(CMD_LOSS, rows[4], rows[4], '0, '0, 32'hffff_ffff, 32'h8000_0000));
    send_item(make_item(CMD_LOSS, rows[2], rows[5], 6'h3f, '1, 32'hffff_ffff, 32'h7fff_ffff));
    send_item(make_item(CMD_TRAIN, rows[2], rows[5], '0, '0, '0, 32'h7fff_ffff));
    send_item(make_item(CMD_TRAIN, rows[3], rows[5], '0, '0, 32'hffff_ffff, 32'h8000_0000));
    send_item(make_item(CMD_LOAD, rows[0], 12'hfff, 6'd0, 32'h7fff_ffff, '1, '1));
    send_item(make_item(CMD_LOAD, rows[0], 12'hfff, 6'd1, 32'h8000_0000, '1, '1));
    send_item(make_item(CMD_LOAD, rows[1], 12'h000, 6'd0, 32'h7fff_ffff, '0, '0));
    send_item(make_item(CMD_LOAD, rows[1], 12'h000, 6'd1, 32'h8000_0000, '0, '0));
    send_item(make_item(CMD_LOAD, 12'hfff, 12'h000, 6'h3f, 32'h1234_5678, '0, '0));
    send_item(make_item(CMD_LOAD, 12'h000, 12'h000, 6'(DIM), 32'h1234_5678, '0, '0));
    send_item(make_item(CMD_READ, rows[0], 12'h000, 6'd0, '0, '0, '0));
    send_item(make_item(CMD_READ, rows[0], 12'h000, 6'd1, '0, '0, '0));
    send_item(make_item(CMD_READ, 12'hfff, 12'hfff, 6'h3f, '1, '1, '1));
    send_item(make_item(CMD_READ, 12'h000, 12'h000, 6'(DIM), '0, '0, '0));
    // saturating pair: both rows hold the largest positive and negative element values
    send_item(make_item(CMD_LOSS, rows[0], rows[1], '0, '0, 32'hffff_ffff, 32'h8000_0000));
    send_item(make_item(CMD_TRAIN, rows[0], rows[0], '0, '0, 32'hffff_ffff, 32'h7fff_ffff));
    send_item(make_item(CMD_TRAIN, rows[0], rows[1], '0, '0, 32'hffff_ffff, 32'h8000_0000));
    send_item(make_item(CMD_READ, rows[0], 12'h000, 6'd0, '0, '0, '0));
    in_valid <= 1'b0;

    // largest step and offset, with a long receiver hold-off
    write_reg(REG_IDX_LR, 64'hffff_ffff);
    write_reg(REG_IDX_BIAS, 64'h7fff_ffff_ffff);
    fork
      begin
        hold_rx = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_rx = 1'b0;
      end
    join_none
    random_phase(110);
    in_valid <= 1'b0;

    write_reg(REG_IDX_LR, 64'd0);
    write_reg(REG_IDX_BIAS, 64'h8000_0000_0000);
    idle_on = 1'b0;
    random_phase(110);
    idle_on = 1'b1;
    in_valid <= 1'b0;

    write_reg(REG_IDX_LR, 64'($urandom));
    write_reg(REG_IDX_BIAS, {16'h0, 16'($urandom), 32'($urandom)});
    random_phase(110);
    in_valid <= 1'b0;

    write_reg(REG_IDX_LR, 64'd1 << 30);
    write_reg(REG_IDX_BIAS, 64'd0);
    random_phase(110);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
